### src/ifcg_pkg.sv
// ============================================================================
// ifcg_pkg: shared types and constants of the instruction fuzz generator
// Search modes, register map, controller/datapath command and status
// structs, the golden mixing constant and the targeted opcode corpus.
// ============================================================================
`default_nettype none

package ifcg_pkg;

    // Storage limit default and hard cap on the bytes of one candidate
    localparam int MAX_INSN_BYTES_DEF = 16;
    localparam int RESULT_LIMIT       = 16;

    // Configuration port
    localparam int CFG_W  = 5;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_SEARCH_MODE     = 2'd0;
    localparam logic [1:0] REG_LENGTH_SETTING  = 2'd1;
    localparam logic [1:0] REG_BUFFER_CAPACITY = 2'd2;

    localparam logic [CFG_W-1:0] LENGTH_RESET   = 5'd15;
    localparam logic [CFG_W-1:0] CAPACITY_RESET = 5'd16;

    // Mixing constant for random mode, split into the two halves
    localparam logic [31:0] GOLDEN_LO = 32'h7F4A7C15;
    localparam logic [31:0] GOLDEN_HI = 32'h9E3779B9;

    localparam logic [7:0] PAD_BYTE = 8'h90;
    localparam logic [7:0] ALL_ONES = 8'hFF;

    typedef enum logic [1:0] {
        MODE_RANDOM   = 2'd0,
        MODE_BRUTE    = 2'd1,
        MODE_TARGETED = 2'd2,
        MODE_TUNNEL   = 2'd3
    } t_mode;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture the input beat
        logic setup;     // tunnel init / pointer set-up
        logic mul_step;  // one step of the index mixing product
        logic walk;      // one step of the tunnel carry walk
        logic emit;      // load the next candidate byte into the output reg
        logic exhaust;   // load the exhausted marker into the output reg
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        t_mode mode;     // mode captured with the request
        logic  fresh;    // tunnel vector restarts on this request
        logic  mul_done; // final accumulate of the mixing product
        logic  walk_ff;  // byte under the carry pointer is 0xFF
        logic  ptr_zero; // carry pointer sits on byte 0
        logic  last;     // byte under the pointer is the final one
        logic  out_free; // output register can take a beat
    } t_status;

    // Eight-entry, three-byte opcode corpus for targeted mode
    function automatic logic [7:0] target_byte(input logic [2:0] entry,
                                               input logic [1:0] pos);
        logic [23:0] row;
        case (entry)
            3'd0:    row = 24'hD6_90_90;
            3'd1:    row = 24'hF1_90_90;
            3'd2:    row = 24'h82_C0_00;
            3'd3:    row = 24'h0F_04_90;
            3'd4:    row = 24'h0F_0A_90;
            3'd5:    row = 24'h0F_24_C0;
            3'd6:    row = 24'h0F_26_C0;
            default: row = 24'h0F_39_90;
        endcase
        case (pos)
            2'd0:    target_byte = row[23:16];
            2'd1:    target_byte = row[15:8];
            default: target_byte = row[7:0];
        endcase
    endfunction

endpackage

`default_nettype wire

### src/ifcg_cfg.sv
// ============================================================================
// ifcg_cfg: configuration registers
// APB-style register file holding the search mode, the requested length and
// the buffer capacity, plus the clamped candidate length derived from them.
// ============================================================================
`default_nettype none

module ifcg_cfg
    import ifcg_pkg::*;
#(
    parameter int LEN_LIMIT = RESULT_LIMIT,
    localparam int LW = $clog2(LEN_LIMIT + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_mode                  o_mode,
    output logic      [LW-1:0]     o_len
);

    localparam logic [CFG_W-1:0] LIM = CFG_W'(LEN_LIMIT);

    t_mode            r_mode;
    logic [CFG_W-1:0] r_length;
    logic [CFG_W-1:0] r_capacity;
    logic [1:0]       reg_idx;
    logic             wr_en;
    logic [CFG_W-1:0] len_c;
    logic [CFG_W-1:0] cap_c;
    logic [CFG_W-1:0] n_len;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_TUNNEL;
            r_length   <= LENGTH_RESET;
            r_capacity <= CAPACITY_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SEARCH_MODE:     r_mode     <= t_mode'(pwdata[1:0]);
                REG_LENGTH_SETTING:  r_length   <= pwdata[CFG_W-1:0];
                REG_BUFFER_CAPACITY: r_capacity <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back
    always_comb begin
        case (reg_idx)
            REG_SEARCH_MODE:     prdata = {{(DATA_W-2){1'b0}}, r_mode};
            REG_LENGTH_SETTING:  prdata = {{(DATA_W-CFG_W){1'b0}}, r_length};
            REG_BUFFER_CAPACITY: prdata = {{(DATA_W-CFG_W){1'b0}}, r_capacity};
            default:             prdata = '0;
        endcase
    end

    // Candidate length: both settings held to 1..LEN_LIMIT, smaller one wins
    always_comb begin
        len_c = (r_length == '0) ? CFG_W'(1) : r_length;
        if (len_c > LIM) len_c = LIM;
        cap_c = (r_capacity == '0) ? CFG_W'(1) : r_capacity;
        if (cap_c > LIM) cap_c = LIM;
        n_len = (len_c < cap_c) ? len_c : cap_c;
    end

    assign o_mode = r_mode;
    assign o_len  = LW'(n_len);

endmodule

`default_nettype wire

### src/ifcg_ctrl.sv
// ============================================================================
// ifcg_ctrl: request sequencer
// One-hot state machine stepping each request through set-up, the mixing
// product or the tunnel carry walk, and the serial byte emission.
// ============================================================================
`default_nettype none

module ifcg_ctrl
    import ifcg_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  t_status      i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SETUP   = 6'b000010,
        S_MUL     = 6'b000100,
        S_WALK    = 6'b001000,
        S_EMIT    = 6'b010000,
        S_EXHAUST = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                if (i_status.mode == MODE_RANDOM)
                    n_state = S_MUL;
                else if (i_status.mode == MODE_TUNNEL && !i_status.fresh)
                    n_state = S_WALK;
                else
                    n_state = S_EMIT;
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_status.mul_done) n_state = S_EMIT;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (!i_status.walk_ff)     n_state = S_EMIT;
                else if (i_status.ptr_zero) n_state = S_EXHAUST;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last) n_state = S_IDLE;
                end
            end
            S_EXHAUST: begin
                if (i_status.out_free) begin
                    o_cmd.exhaust = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

### src/ifcg_dp.sv
// ============================================================================
// ifcg_dp: candidate datapath
// Request capture, shared 32x32 multiplier for the index mix, tunnel byte
// vector with its carry pointer, byte selection and the output register.
// ============================================================================
`default_nettype none

module ifcg_dp
    import ifcg_pkg::*;
#(
    parameter int LEN_LIMIT = RESULT_LIMIT,
    localparam int LW = $clog2(LEN_LIMIT + 1),
    localparam int IW = $clog2(LEN_LIMIT)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  t_mode              i_mode,
    input  wire logic [LW-1:0] i_len,
    input  wire logic [63:0]   i_candidate_index,
    input  wire logic [4:0]    i_executed_length,
    input  wire logic [63:0]   i_random_word_low,
    input  wire logic [63:0]   i_random_word_high,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [7:0]         o_candidate_byte,
    output logic               o_final_byte,
    output logic               o_space_exhausted
);

    // Captured request
    logic [63:0]   r_idx;
    logic [4:0]    r_fb;
    logic [63:0]   r_rwl;
    logic [63:0]   r_rwh;
    t_mode         r_mode;
    logic [LW-1:0] r_len;

    // Mixing product
    logic [1:0]    r_mstep;
    logic [63:0]   r_prod;
    logic [63:0]   r_mix;
    logic [31:0]   a_op;
    logic [31:0]   b_op;
    logic [63:0]   prod;

    // Tunnel state and shared byte pointer
    logic [7:0]    r_wb [LEN_LIMIT];
    logic          r_started;
    logic [IW-1:0] r_ptr;
    logic [IW-1:0] start_pos;
    logic [7:0]    rd_byte;
    logic          fresh;

    // Byte selection
    logic          ptr_hi;
    logic [63:0]   rnd_word;
    logic [7:0]    n_byte;

    // Output register
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_final;
    logic          r_out_ex;
    logic          out_free;
    logic          last;

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx  <= i_candidate_index;
            r_fb   <= i_executed_length;
            r_rwl  <= i_random_word_low;
            r_rwh  <= i_random_word_high;
            r_mode <= i_mode;
            r_len  <= i_len;
        end
    end

    // Index mix, low 64 bits of idx * golden: lo*lo, then the two cross
    // terms folded into the upper half; one product per cycle
    assign a_op = (r_mstep == 2'd1) ? r_idx[63:32] : r_idx[31:0];
    assign b_op = (r_mstep == 2'd2) ? GOLDEN_HI : GOLDEN_LO;
    assign prod = a_op * b_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mstep <= '0;
        end else if (i_cmd.load) begin
            r_mstep <= '0;
        end else if (i_cmd.mul_step) begin
            r_mstep <= r_mstep + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_step) begin
            r_prod <= prod;
            case (r_mstep)
                2'd0:    ;
                2'd1:    r_mix <= r_prod;
                default: r_mix[63:32] <= r_mix[63:32] + r_prod[31:0];
            endcase
        end
    end

    // Tunnel carry start: executed length minus one, or the last byte
    assign fresh = !r_started || (r_idx == '0);
    assign start_pos = ((r_fb == '0) || (r_fb > 5'(r_len)))
                     ? IW'(r_len - LW'(1)) : IW'(r_fb - 5'd1);
    assign rd_byte = r_wb[r_ptr];

    // Tunnel vector: clear on restart, odometer step during the walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            for (int j = 0; j < LEN_LIMIT; j++) r_wb[j] <= '0;
        end else if (i_cmd.setup && r_mode == MODE_TUNNEL && fresh) begin
            r_started <= 1'b1;
            for (int j = 0; j < LEN_LIMIT; j++) r_wb[j] <= '0;
        end else if (i_cmd.walk) begin
            if (rd_byte == ALL_ONES) begin
                r_wb[r_ptr] <= '0;
            end else begin
                for (int j = 0; j < LEN_LIMIT; j++) begin
                    if (IW'(j) > r_ptr && LW'(j) < r_len) r_wb[j] <= '0;
                end
                r_wb[r_ptr] <= rd_byte + 8'd1;
            end
        end
    end

    // Pointer: carry position during the walk, byte index during emission
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            if (r_mode == MODE_TUNNEL && !fresh) r_ptr <= start_pos;
            else                                 r_ptr <= '0;
        end else if (i_cmd.walk) begin
            if (rd_byte != ALL_ONES) r_ptr <= '0;
            else if (r_ptr != '0)    r_ptr <= r_ptr - IW'(1);
        end else if (i_cmd.emit) begin
            r_ptr <= r_ptr + IW'(1);
        end
    end

    // Byte for the current pointer
    assign ptr_hi   = (LW'(r_ptr) >= LW'(8));
    assign rnd_word = (ptr_hi ? r_rwh : r_rwl) ^ r_mix;
    assign last     = ((LW'(r_ptr) + LW'(1)) == r_len);

    always_comb begin
        case (r_mode)
            MODE_RANDOM:   n_byte = rnd_word[{r_ptr[2:0], 3'b000} +: 8];
            MODE_BRUTE:    n_byte = ptr_hi ? 8'h00 : r_idx[{r_ptr[2:0], 3'b000} +: 8];
            MODE_TARGETED: n_byte = (LW'(r_ptr) < LW'(3))
                                  ? target_byte(r_idx[2:0], r_ptr[1:0]) : PAD_BYTE;
            default:       n_byte = rd_byte;
        endcase
    end

    // Output register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.exhaust) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte  <= n_byte;
            r_out_final <= last;
            r_out_ex    <= 1'b0;
        end else if (i_cmd.exhaust) begin
            r_out_byte  <= '0;
            r_out_final <= 1'b1;
            r_out_ex    <= 1'b1;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_candidate_byte  = r_out_byte;
    assign o_final_byte      = r_out_final;
    assign o_space_exhausted = r_out_ex;

    always_comb begin
        o_status          = '0;
        o_status.mode     = r_mode;
        o_status.fresh    = fresh;
        o_status.mul_done = (r_mstep == 2'd3);
        o_status.walk_ff  = (rd_byte == ALL_ONES);
        o_status.ptr_zero = (r_ptr == '0);
        o_status.last     = last;
        o_status.out_free = out_free;
    end

    // A held beat is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(i_cmd.emit || i_cmd.exhaust))
        else $error("output beat overwritten while stalled");

    // Once started, the tunnel vector stays started
    a_started_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |=> r_started)
        else $error("tunnel started flag dropped");

    // An increment ends the walk and rewinds the pointer for emission
    a_walk_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.walk && rd_byte != ALL_ONES) |=> (r_ptr == '0))
        else $error("pointer not rewound after tunnel increment");

    // Exhaustion only arises from a tunnel walk off byte 0
    a_exhaust_tunnel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exhaust |-> (r_mode == MODE_TUNNEL && r_ptr == '0 && r_wb[0] == '0))
        else $error("exhausted marker outside a tunnel carry-out");

endmodule

`default_nettype wire

### src/instruction_fuzz_candidate_generator.sv
// Each request beat produces n candidate bytes, one output beat per byte with
// the final one flagged; n is length_setting (0 read as 1) held to the buffer
// capacity and to the storage limit. In random mode the 64-bit index mix is
// built in four steps on a single 32x32 multiplier; in tunnel mode, unless the
// vector restarts, the carry walks w stored bytes (1 to n) one per cycle, and
// an exhausted tunnel space returns one flagged beat. Output stalls hold the
// byte emission. The next request is taken once the previous one has handed
// its last byte to the output register.
// ============================================================================
// instruction_fuzz_candidate_generator: top level
// Configuration registers, request sequencer and candidate datapath.
// ============================================================================
`default_nettype none

module instruction_fuzz_candidate_generator
    import ifcg_pkg::*;
#(
    parameter int MAX_INSN_BYTES = MAX_INSN_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // request channel
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [63:0]       i_candidate_index,
    input  wire logic [4:0]        i_executed_length,
    input  wire logic [63:0]       i_random_word_low,
    input  wire logic [63:0]       i_random_word_high,
    // result channel
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [7:0]             o_candidate_byte,
    output logic                   o_final_byte,
    output logic                   o_space_exhausted,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    localparam int LEN_LIMIT = (MAX_INSN_BYTES < RESULT_LIMIT)
                             ? MAX_INSN_BYTES : RESULT_LIMIT;
    localparam int LW = $clog2(LEN_LIMIT + 1);

    t_mode         cfg_mode;
    logic [LW-1:0] cfg_len;
    t_cmd          cmd;
    t_status       status;

    ifcg_cfg #(
        .LEN_LIMIT (LEN_LIMIT)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_mode  (cfg_mode),
        .o_len   (cfg_len)
    );

    ifcg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ifcg_dp #(
        .LEN_LIMIT (LEN_LIMIT)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_mode             (cfg_mode),
        .i_len              (cfg_len),
        .i_candidate_index  (i_candidate_index),
        .i_executed_length  (i_executed_length),
        .i_random_word_low  (i_random_word_low),
        .i_random_word_high (i_random_word_high),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_candidate_byte   (o_candidate_byte),
        .o_final_byte       (o_final_byte),
        .o_space_exhausted  (o_space_exhausted)
    );

endmodule

`default_nettype wire

### test/testbench.sv
// ============================================================================
// testbench: instruction fuzz candidate generator
// Drives candidate requests through the valid/ready request channel, predicts
// every candidate byte from a shadow copy of the configuration and the tunnel
// vector, and checks each output beat in order against that prediction.
// Both channels idle at random. The register settings are swept through all
// search modes and the length/capacity extremes, and a long tunnel run steps
// the leading byte through its whole range into exhaustion.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ifcg_pkg::*;

    localparam int VEC_BYTES    = MAX_INSN_BYTES_DEF;
    localparam int STALL_LIMIT  = 2000;
    localparam logic [63:0] GOLDEN_MIX = {GOLDEN_HI, GOLDEN_LO};
    // Targeted corpus, entry 0 in the top bits, three bytes per entry
    localparam logic [191:0] CORPUS = {
        8'hD6, 8'h90, 8'h90,  8'hF1, 8'h90, 8'h90,
        8'h82, 8'hC0, 8'h00,  8'h0F, 8'h04, 8'h90,
        8'h0F, 8'h0A, 8'h90,  8'h0F, 8'h24, 8'hC0,
        8'h0F, 8'h26, 8'hC0,  8'h0F, 8'h39, 8'h90
    };

    typedef struct packed {
        logic [7:0] value;
        logic       is_last;
        logic       exhausted;
    } t_beat;

    // DUT connections
    logic              i_clk              = 1'b0;
    logic              i_rst_n            = 1'b0;
    logic              i_in_valid         = 1'b0;
    logic              o_in_ready;
    logic [63:0]       i_candidate_index  = '0;
    logic [4:0]        i_executed_length  = '0;
    logic [63:0]       i_random_word_low  = '0;
    logic [63:0]       i_random_word_high = '0;
    logic              o_out_valid;
    logic              i_out_ready        = 1'b0;
    logic [7:0]        o_candidate_byte;
    logic              o_final_byte;
    logic              o_space_exhausted;
    logic              psel               = 1'b0;
    logic              penable            = 1'b0;
    logic              pwrite             = 1'b0;
    logic [ADDR_W-1:0] paddr              = '0;
    logic [DATA_W-1:0] pwdata             = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Shadow configuration and tunnel state
    t_mode      cfg_mode     = MODE_TUNNEL;
    logic [4:0] cfg_length   = LENGTH_RESET;
    logic [4:0] cfg_capacity = CAPACITY_RESET;
    logic [7:0] tunnel_vec [VEC_BYTES] = '{default: 8'h00};
    bit         tunnel_live  = 1'b0;

    t_beat expected_beats [$];
    t_beat want;
    int    mismatch_count = 0;
    int    idle_cycles    = 0;

    // Sender burst shaping and receiver stall pattern
    int       burst_left   = 0;
    bit       sender_eager = 1'b0;
    int       stall_left   = 0;
    int       stall_pct    = 0;
    logic [7:0] pattern_clock = '0;

    instruction_fuzz_candidate_generator i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_candidate_index  (i_candidate_index),
        .i_executed_length  (i_executed_length),
        .i_random_word_low  (i_random_word_low),
        .i_random_word_high (i_random_word_high),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_candidate_byte   (o_candidate_byte),
        .o_final_byte       (o_final_byte),
        .o_space_exhausted  (o_space_exhausted),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Candidate length: length register (0 read as 1) held to capacity and limits
    function automatic int unsigned candidate_bytes();
        int unsigned n;
        int unsigned cap;
        n   = cfg_length;
        cap = cfg_capacity;
        if (n < 1) n = 1;
        if (n > VEC_BYTES) n = VEC_BYTES;
        if (cap < 1) cap = 1;
        if (n > cap) n = cap;
        if (n > RESULT_LIMIT) n = RESULT_LIMIT;
        return n;
    endfunction

    // Works out the beats one accepted request produces and queues them
    task automatic predict_candidate(input logic [63:0] idx, input logic [4:0] exec_len,
                                     input logic [63:0] word_lo, input logic [63:0] word_hi);
        int unsigned n;
        int          p;
        int          entry;
        logic [63:0] mix;
        logic [63:0] w;
        logic [7:0]  cand [RESULT_LIMIT];
        bit          walking;
        bit          carried;
        t_beat       beat;
        n       = candidate_bytes();
        mix     = idx * GOLDEN_MIX;
        carried = 1'b0;
        entry   = int'(idx[2:0]);
        for (int i = 0; i < RESULT_LIMIT; i++) cand[i] = 8'h00;
        case (cfg_mode)
            MODE_RANDOM: begin
                for (int i = 0; i < n; i++) begin
                    w = ((i < 8) ? word_lo : word_hi) ^ mix;
                    cand[i] = w[8*(i%8) +: 8];
                end
            end
            MODE_BRUTE: begin
                for (int i = 0; i < n && i < 8; i++) cand[i] = idx[8*i +: 8];
            end
            MODE_TARGETED: begin
                for (int i = 0; i < n; i++)
                    cand[i] = (i < 3) ? CORPUS[191 - 8*(3*entry + i) -: 8] : PAD_BYTE;
            end
            default: begin
                if (!tunnel_live || idx == '0) begin
                    // first call or index zero restarts the vector
                    for (int i = 0; i < VEC_BYTES; i++) tunnel_vec[i] = 8'h00;
                    tunnel_live = 1'b1;
                end else begin
                    p = int'((exec_len > 0) ? exec_len - 1 : n - 1);
                    if (p >= n) p = n - 1;
                    carried = 1'b1;
                    walking = 1'b1;
                    // odometer step: 0xFF bytes roll over and carry leftwards
                    while (walking) begin
                        if (tunnel_vec[p] == ALL_ONES) begin
                            tunnel_vec[p] = 8'h00;
                            if (p == 0) walking = 1'b0;
                            else p--;
                        end else begin
                            tunnel_vec[p] = tunnel_vec[p] + 8'd1;
                            carried = 1'b0;
                            walking = 1'b0;
                        end
                    end
                    if (!carried)
                        for (int k = p + 1; k < n; k++) tunnel_vec[k] = 8'h00;
                end
                for (int i = 0; i < n; i++) cand[i] = tunnel_vec[i];
            end
        endcase
        if (carried) begin
            // space exhausted: one flagged beat, no candidate
            beat.value     = 8'h00;
            beat.is_last   = 1'b1;
            beat.exhausted = 1'b1;
            expected_beats.push_back(beat);
        end else begin
            for (int i = 0; i < n; i++) begin
                beat.value     = cand[i];
                beat.is_last   = (i == n - 1);
                beat.exhausted = 1'b0;
                expected_beats.push_back(beat);
            end
        end
    endtask

    // One request beat, with random gaps between bursts
    task automatic send_request(input logic [63:0] idx, input logic [4:0] exec_len,
                                input logic [63:0] word_lo, input logic [63:0] word_hi);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (sender_eager || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid         <= 1'b1;
        i_candidate_index  <= idx;
        i_executed_length  <= exec_len;
        i_random_word_low  <= word_lo;
        i_random_word_high <= word_hi;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        burst_left--;
        predict_candidate(idx, exec_len, word_lo, word_hi);
    endtask

    // Hold the request channel quiet until every predicted beat has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
    endtask

    // APB setup and access phases; psel stays up across back-to-back writes
    task automatic write_register(input logic [1:0] reg_idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (reg_idx)
            REG_SEARCH_MODE:     cfg_mode     = t_mode'(value[1:0]);
            REG_LENGTH_SETTING:  cfg_length   = value[4:0];
            REG_BUFFER_CAPACITY: cfg_capacity = value[4:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input t_mode mode, input logic [4:0] length,
                                input logic [4:0] capacity);
        drain_results();
        write_register(REG_SEARCH_MODE, DATA_W'(mode));
        write_register(REG_LENGTH_SETTING, DATA_W'(length));
        write_register(REG_BUFFER_CAPACITY, DATA_W'(capacity));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Reset defaults: tunnel mode, 15 bytes; first call, carry positions, restart
    task automatic test_reset_defaults();
        send_request(rand64() | 64'd1, 5'd0, rand64(), rand64());
        send_request(rand64() | 64'd1, 5'd0, rand64(), rand64());
        send_request(rand64() | 64'd1, 5'd31, rand64(), rand64());
        send_request(rand64() | 64'd1, 5'd1, rand64(), rand64());
        send_request(64'd0, 5'd7, rand64(), rand64());
    endtask

    task automatic test_random_mode();
        apply_config(MODE_RANDOM, 5'd16, 5'd16);
        send_request(64'd0, 5'd0, '1, '1);
        send_request('1, 5'd31, '0, '0);
        send_request(rand64(), 5'($urandom_range(0, 31)), rand64(), rand64());
    endtask

    task automatic test_brute_mode();
        apply_config(MODE_BRUTE, 5'd16, 5'd16);
        send_request('1, 5'd16, rand64(), rand64());
        send_request(64'h0123_4567_89AB_CDEF, 5'd0, rand64(), rand64());
    endtask

    task automatic test_targeted_corpus();
        logic [63:0] idx;
        apply_config(MODE_TARGETED, 5'd16, 5'd16);
        for (int e = 0; e < 8; e++) begin
            idx = rand64();
            idx[2:0] = 3'(e);
            send_request(idx, 5'($urandom_range(0, 31)), rand64(), rand64());
        end
    endtask

    // Zero length, zero capacity, oversized values and capacity below length
    task automatic test_length_limits();
        apply_config(MODE_RANDOM, 5'd0, 5'd16);
        send_request(rand64(), 5'd3, rand64(), rand64());
        apply_config(MODE_BRUTE, 5'd16, 5'd0);
        send_request(rand64(), 5'd3, rand64(), rand64());
        apply_config(MODE_TARGETED, 5'd31, 5'd31);
        send_request(rand64(), 5'd3, rand64(), rand64());
        apply_config(MODE_RANDOM, 5'd9, 5'd5);
        send_request(rand64(), 5'd3, rand64(), rand64());
    endtask

    // Tunnel vector must survive the detour through the other modes
    task automatic test_tunnel_resume();
        apply_config(MODE_TUNNEL, 5'd15, 5'd16);
        send_request(rand64() | 64'd1, 5'd5, rand64(), rand64());
        send_request(rand64() | 64'd1, 5'd0, rand64(), rand64());
    endtask

    // Random settings per phase, random requests within
    task automatic test_mixed_random();
        t_mode       mode;
        logic [4:0]  length;
        logic [4:0]  capacity;
        logic [63:0] idx;
        for (int phase = 0; phase < 8; phase++) begin
            mode = t_mode'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0:       length = 5'd0;
                1:       length = 5'($urandom_range(17, 31));
                2:       length = 5'd16;
                default: length = 5'($urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 9))
                0:       capacity = 5'd0;
                1:       capacity = 5'($urandom_range(17, 31));
                2:       capacity = 5'd16;
                default: capacity = 5'($urandom_range(1, 16));
            endcase
            sender_eager = ($urandom_range(0, 2) == 0);
            apply_config(mode, length, capacity);
            for (int k = 0; k < 4; k++) begin
                case ($urandom_range(0, 9))
                    0:       idx = '0;
                    1:       idx = '1;
                    2:       idx = 64'($urandom_range(0, 15));
                    default: idx = rand64();
                endcase
                send_request(idx, 5'($urandom_range(0, 31)), rand64(), rand64());
            end
        end
        sender_eager = 1'b0;
    endtask

    // Two-byte tunnel: run the leading byte up to 0xFF, step the second byte
    // a few times, then carry out of the leading byte and carry on after it
    task automatic test_tunnel_sweep();
        logic [63:0] idx;
        logic [4:0]  exec_len;
        apply_config(MODE_TUNNEL, 5'd2, 5'd16);
        send_request(64'd0, 5'($urandom_range(0, 31)), rand64(), rand64());
        for (int k = 0; k < 263; k++) begin
            idx = rand64();
            if (idx == '0) idx = 64'd1;
            if (k >= 255 && k < 259)
                exec_len = ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom_range(2, 31));
            else
                exec_len = 5'd1;
            send_request(idx, exec_len, rand64(), rand64());
        end
    endtask

    // Result checker: each output beat against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat, candidate_byte %h final %b exhausted %b",
                         $realtime, o_candidate_byte, o_final_byte, o_space_exhausted);
                mismatch_count++;
            end else begin
                want = expected_beats.pop_front();
                if (o_candidate_byte !== want.value) begin
                    $display("%0t: candidate_byte expected %h got %h",
                             $realtime, want.value, o_candidate_byte);
                    mismatch_count++;
                end
                if (o_final_byte !== want.is_last) begin
                    $display("%0t: final_byte expected %b got %b",
                             $realtime, want.is_last, o_final_byte);
                    mismatch_count++;
                end
                if (o_space_exhausted !== want.exhausted) begin
                    $display("%0t: space_exhausted expected %b got %b",
                             $realtime, want.exhausted, o_space_exhausted);
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver back-pressure: stall runs whose density changes whenever the 8-bit pattern clock wraps
    always @(posedge i_clk) begin
        pattern_clock <= pattern_clock + 8'd1;
        if (pattern_clock == 8'd0) begin
            case ($urandom_range(0, 3))
                0:       stall_pct <= 0;
                1:       stall_pct <= 15;
                2:       stall_pct <= 40;
                default: stall_pct <= 80;
            endcase
        end
        if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct) stall_left <= $urandom_range(1, 8);
        end
    end

    // Watchdog: too long without any beat or register access
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_random_mode();
        test_brute_mode();
        test_targeted_corpus();
        test_length_limits();
        test_tunnel_resume();
        test_mixed_random();
        test_tunnel_sweep();
        drain_results();
        // let any stray beat show itself
        repeat (32) @(posedge i_clk);
        if (mismatch_count == 0 && expected_beats.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
